[hdl/stereo_audio_spatializer_top_assert.svh]
// Assertion macros for the spatializer top level.
// Depends on nothing; included by stereo_audio_spatializer_top.sv.
`ifndef STEREO_AUDIO_SPATIALIZER_TOP_ASSERT_SVH
`define STEREO_AUDIO_SPATIALIZER_TOP_ASSERT_SVH

// same-cycle implication
`define SSP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spatializer implication check failed");

// next-cycle implication
`define SSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spatializer next-cycle check failed");

`endif

[hdl/ssp_pkg.sv]
// Shared types and constants of the stereo audio spatializer.
// No dependencies; used by the top, ssp_unit, ssp_atten and the testbench.
package ssp_pkg;

   localparam int OFF_W       = 33;   // signed offset component
   localparam int UNIT_W      = 32;   // signed Q2.30 unit component
   localparam int NORM_W      = 30;   // normalized magnitude
   localparam int ATT_W       = 17;
   localparam int GAIN_W      = 15;
   localparam int PAN_W       = 16;
   localparam int CFG_W       = 32;

   localparam int ISQ_DIST_IW = 64;
   localparam int ISQ_UNIT_IW = 62;
   localparam int ISQ_PAN_IW  = 34;
   localparam int DIV_T_QW    = 16;
   localparam int DIV_U_QW    = 31;

   localparam int LAT_UNIT = 6 + ISQ_UNIT_IW / 2 + DIV_U_QW + 1;
   localparam int LAT_ATT  = 4 + ISQ_DIST_IW / 2 + 2 + DIV_T_QW + 3;
   localparam int LAT_ROOT = ISQ_PAN_IW / 2;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DISTANCE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DISTANCE = 1'b1;

   localparam logic [CFG_W-1:0] MIN_DIST_RESET = 32'd65536;
   localparam logic [CFG_W-1:0] MAX_DIST_RESET = 32'd6553600;
   localparam logic [CFG_W-1:0] MIN_FLOOR      = 32'd66;

   localparam logic [6:0] NEAR_ZERO_SQ = 7'd42;
   localparam logic [2:0] NEAR_ZERO_MAG = 3'd6;
   localparam logic signed [UNIT_W-1:0] UNIT_ONE = 32'sh4000_0000;
   localparam logic signed [63:0] PAN_ROUND = 64'sh0000_1000_0000_0000;
   localparam logic [ATT_W-1:0] ATT_ONE = 17'd65536;

   typedef logic [2:0][OFF_W-1:0]  vec_type;
   typedef logic [2:0][UNIT_W-1:0] unit_type;

   typedef struct packed {
      logic               enabled;
      logic signed [15:0] volume;
      logic signed [31:0] source_x;
      logic signed [31:0] source_y;
      logic signed [31:0] source_z;
      logic signed [31:0] listener_x;
      logic signed [31:0] listener_y;
      logic signed [31:0] listener_z;
      logic signed [31:0] ear_axis_x;
      logic signed [31:0] ear_axis_y;
      logic signed [31:0] ear_axis_z;
   } req_type;

   typedef struct packed {
      logic [GAIN_W-1:0]       gain;
      logic [GAIN_W-1:0]       left_gain;
      logic [GAIN_W-1:0]       right_gain;
      logic [ATT_W-1:0]        attenuation;
      logic signed [PAN_W-1:0] pan;
      logic                    audible;
   } rsp_type;

endpackage

[hdl/stereo_audio_spatializer_top.sv]
// Stereo spatializer: an accepted source's valid passes valid_ff, the u_vld_dly line and rsp_valid_ff.
// One source per clock while busy is low; busy holds start off only after reset.
// Latency is set by the unit-vector path: two 31-step pipelined units (root, divide).
// Synchronous reset clears the valid line and loads the distance registers; busy is
// high only in the cycle after a reset edge. Results cannot be stalled.
// Depends on ssp_pkg, ssp_delay, ssp_isqrt, ssp_unit, ssp_atten and the assert header.
`include "stereo_audio_spatializer_top_assert.svh"

module stereo_audio_spatializer_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  ssp_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   output ssp_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [ssp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ssp_pkg::CFG_W-1:0]         csr_wdata
);

   localparam int ATT_DLY  = ssp_pkg::LAT_UNIT - ssp_pkg::LAT_ATT;
   localparam int VLD_DLY  = ssp_pkg::LAT_UNIT + 3 + ssp_pkg::LAT_ROOT;
   localparam int GAIN_DLY = ssp_pkg::LAT_ROOT + 2;
   localparam int RSP_LAT  = VLD_DLY + 1;
   localparam int RW       = ssp_pkg::ISQ_PAN_IW / 2;
   localparam int GW       = ssp_pkg::GAIN_W;
   localparam int AW       = ssp_pkg::ATT_W;

   logic                      busy_ff;
   logic [ssp_pkg::CFG_W-1:0] min_ff, max_ff;
   logic                      valid_ff, en_ff;
   logic signed [15:0]        vol_ff;
   ssp_pkg::vec_type          off_ff, ear_ff, off_in, ear_in;
   ssp_pkg::unit_type         ud, ur, urs;
   logic                      near_off, near_ear;
   logic [AW-1:0]             att, att_d, att1_ff, att_o;
   logic signed [15:0]        vol_d;
   logic [1:0]                ve_d;
   logic signed [63:0]        prod1_ff [3];
   logic [GW-1:0]             gain1_ff, gain_o;
   logic [GW-1:0]             vol_pos;
   logic [31:0]               gprod;
   logic                      near1_ff, near2_ff;
   logic signed [63:0]        dot2_ff;
   logic signed [63:0]        dot_sh;
   logic signed [18:0]        pan_raw;
   logic signed [15:0]        pan3_ff, pan_in, pan_d;
   logic signed [17:0]        lsum, rsum;
   logic [RW-1:0]             lroot, rroot;
   logic [31:0]               lprod, rprod;
   logic                      rsp_valid_ff;
   ssp_pkg::rsp_type          rsp_ff, rsp_in;

   // reset and busy
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end
   assign busy = busy_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= ssp_pkg::MIN_DIST_RESET;
         max_ff <= ssp_pkg::MAX_DIST_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ssp_pkg::CSR_MIN_DISTANCE: min_ff <= csr_wdata;
            ssp_pkg::CSR_MAX_DISTANCE: max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input beat: offsets and ear axis in 33 bits
   always_comb begin
      off_in[0] = {req_data.source_x[31], req_data.source_x}
                - {req_data.listener_x[31], req_data.listener_x};
      off_in[1] = {req_data.source_y[31], req_data.source_y}
                - {req_data.listener_y[31], req_data.listener_y};
      off_in[2] = {req_data.source_z[31], req_data.source_z}
                - {req_data.listener_z[31], req_data.listener_z};
      ear_in[0] = {req_data.ear_axis_x[31], req_data.ear_axis_x};
      ear_in[1] = {req_data.ear_axis_y[31], req_data.ear_axis_y};
      ear_in[2] = {req_data.ear_axis_z[31], req_data.ear_axis_z};
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= start && !busy;
      en_ff  <= req_data.enabled;
      vol_ff <= req_data.volume;
      off_ff <= off_in;
      ear_ff <= ear_in;
   end

   ssp_unit u_dir (
      .clock  (clock),
      .reset  (reset),
      .vec_i  (off_ff),
      .unit_o (ud),
      .near_o (near_off)
   );

   ssp_unit u_ear (
      .clock  (clock),
      .reset  (reset),
      .vec_i  (ear_ff),
      .unit_o (ur),
      .near_o (near_ear)
   );

   ssp_atten u_att (
      .clock (clock),
      .reset (reset),
      .off_i (off_ff),
      .min_i (min_ff),
      .max_i (max_ff),
      .att_o (att)
   );

   ssp_delay #(.W(AW), .N(ATT_DLY)) u_att_dly (
      .clock (clock),
      .reset (reset),
      .d_i   (att),
      .q_o   (att_d)
   );

   ssp_delay #(.W(16), .N(ssp_pkg::LAT_UNIT)) u_vol_dly (
      .clock (clock),
      .reset (reset),
      .d_i   (vol_ff),
      .q_o   (vol_d)
   );

   ssp_delay #(.W(2), .N(VLD_DLY)) u_vld_dly (
      .clock (clock),
      .reset (reset),
      .d_i   ({valid_ff, en_ff}),
      .q_o   (ve_d)
   );

   // right vector fallback, dot products and gain
   always_comb begin
      urs[0] = near_ear ? ssp_pkg::UNIT_ONE : ur[0];
      urs[1] = near_ear ? '0 : ur[1];
      urs[2] = near_ear ? '0 : ur[2];
      vol_pos = vol_d[15] ? '0 : vol_d[GW-1:0];
      gprod   = 32'(vol_pos) * 32'(att_d);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) prod1_ff[i] <= $signed(ud[i]) * $signed(urs[i]);
      gain1_ff <= gprod[30:16];
      att1_ff  <= att_d;
      near1_ff <= near_off;
      dot2_ff  <= prod1_ff[0] + prod1_ff[1] + prod1_ff[2] + ssp_pkg::PAN_ROUND;
      near2_ff <= near1_ff;
      pan3_ff  <= pan_in;
   end

   // round to Q1.15 and clamp
   always_comb begin
      dot_sh  = dot2_ff >>> 45;
      pan_raw = dot_sh[18:0];
      if (near2_ff)
         pan_in = '0;
      else if (pan_raw > 19'sd32767)
         pan_in = 16'sd32767;
      else if (pan_raw < -19'sd32768)
         pan_in = -16'sd32768;
      else
         pan_in = pan_raw[15:0];
      lsum = 18'sd32768 - 18'(pan3_ff);
      rsum = 18'sd32768 + 18'(pan3_ff);
   end

   // equal-power roots of (1 -/+ pan)/2
   ssp_isqrt #(.IW(ssp_pkg::ISQ_PAN_IW)) u_lroot (
      .clock  (clock),
      .x_i    ({1'b0, lsum[16:0], 16'b0}),
      .root_o (lroot)
   );

   ssp_isqrt #(.IW(ssp_pkg::ISQ_PAN_IW)) u_rroot (
      .clock  (clock),
      .x_i    ({1'b0, rsum[16:0], 16'b0}),
      .root_o (rroot)
   );

   ssp_delay #(.W(GW + AW), .N(GAIN_DLY)) u_gain_dly (
      .clock (clock),
      .reset (reset),
      .d_i   ({gain1_ff, att1_ff}),
      .q_o   ({gain_o, att_o})
   );

   ssp_delay #(.W(16), .N(ssp_pkg::LAT_ROOT)) u_pan_dly (
      .clock (clock),
      .reset (reset),
      .d_i   (pan3_ff),
      .q_o   (pan_d)
   );

   // result beat; a disabled source gives all zeros
   always_comb begin
      lprod  = 32'(gain_o) * 32'(lroot);
      rprod  = 32'(gain_o) * 32'(rroot);
      rsp_in = '0;
      if (ve_d[0]) begin
         rsp_in.gain        = gain_o;
         rsp_in.left_gain   = lprod[30:16];
         rsp_in.right_gain  = rprod[30:16];
         rsp_in.attenuation = att_o;
         rsp_in.pan         = pan_d;
         rsp_in.audible     = (gain_o != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= ve_d[1];
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `SSP_ASSERT_IMPLY(a_audible, clock, reset, rsp_valid, rsp_data.audible == (rsp_data.gain != '0))
   `SSP_ASSERT_IMPLY(a_side_le_gain, clock, reset, rsp_valid, (rsp_data.left_gain <= rsp_data.gain) && (rsp_data.right_gain <= rsp_data.gain))
   `SSP_ASSERT_IMPLY(a_latency, clock, reset, rsp_valid, $past(start && !busy, RSP_LAT + 1))
   `SSP_ASSERT_NEXT(a_reset_flush, clock, 1'b0, reset, !rsp_valid)

endmodule

[hdl/ssp_delay.sv]
// Fixed-length shift line that carries side data alongside the pipeline.
// No dependencies.
module ssp_delay #(
   parameter int W = 1,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [W-1:0] d_i,
   output logic [W-1:0] q_o
);

   logic [W-1:0] tap_ff [N];

   // shift one tap per clock
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) tap_ff[i] <= '0;
      end else begin
         tap_ff[0] <= d_i;
         for (int i = 1; i < N; i++) tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign q_o = tap_ff[N-1];

endmodule

[hdl/ssp_isqrt.sv]
// Pipelined floor square root, one result bit per stage.
// No dependencies.
module ssp_isqrt #(
   parameter int IW = 64
) (
   input  logic            clock,
   input  logic [IW-1:0]   x_i,
   output logic [IW/2-1:0] root_o
);

   localparam int RW    = IW / 2;
   localparam int REM_W = RW + 3;

   logic [IW-1:0]    x_ff    [RW];
   logic [REM_W-1:0] rem_ff  [RW];
   logic [RW-1:0]    root_ff [RW];

   for (genvar s = 0; s < RW; s++) begin : g_stage
      logic [IW-1:0]    x_cur, x_in;
      logic [REM_W-1:0] rem_cur, rem_sh, trial, rem_in;
      logic [RW-1:0]    root_cur, root_in;

      if (s == 0) begin : g_head
         assign x_cur    = x_i;
         assign rem_cur  = '0;
         assign root_cur = '0;
      end else begin : g_tail
         assign x_cur    = x_ff[s-1];
         assign rem_cur  = rem_ff[s-1];
         assign root_cur = root_ff[s-1];
      end

      // bring down two bits, try 4r+1
      assign rem_sh = {rem_cur[REM_W-3:0], x_cur[IW-1 -: 2]};
      assign trial  = {1'b0, root_cur, 2'b01};
      assign x_in   = {x_cur[IW-3:0], 2'b00};

      always_comb begin
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_cur[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_cur[RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         x_ff[s]    <= x_in;
         rem_ff[s]  <= rem_in;
         root_ff[s] <= root_in;
      end
   end

   assign root_o = root_ff[RW-1];

endmodule

[hdl/ssp_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// No dependencies; the high dividend part must be below the divisor.
module ssp_div #(
   parameter int DW = 32,
   parameter int QW = 16
) (
   input  logic          clock,
   input  logic [DW-1:0] hi_i,
   input  logic [QW-1:0] lo_i,
   input  logic [DW-1:0] den_i,
   output logic [QW-1:0] quo_o
);

   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] lo_ff  [QW];
   logic [DW-1:0] den_ff [QW];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic [DW-1:0] rem_cur, den_cur, rem_in;
      logic [QW-1:0] lo_cur, lo_in;
      logic [DW:0]   rem_sh, dext, diff;
      logic          qbit;

      if (s == 0) begin : g_head
         assign rem_cur = hi_i;
         assign lo_cur  = lo_i;
         assign den_cur = den_i;
      end else begin : g_tail
         assign rem_cur = rem_ff[s-1];
         assign lo_cur  = lo_ff[s-1];
         assign den_cur = den_ff[s-1];
      end

      // shift in next dividend bit, subtract when it fits
      assign rem_sh = {rem_cur, lo_cur[QW-1]};
      assign dext   = {1'b0, den_cur};
      assign diff   = rem_sh - dext;
      assign qbit   = (rem_sh >= dext);
      assign rem_in = qbit ? diff[DW-1:0] : rem_sh[DW-1:0];
      assign lo_in  = {lo_cur[QW-2:0], qbit};

      always_ff @(posedge clock) begin
         rem_ff[s] <= rem_in;
         lo_ff[s]  <= lo_in;
         den_ff[s] <= den_cur;
      end
   end

   assign quo_o = lo_ff[QW-1];

endmodule

[hdl/ssp_unit.sv]
// Unit vector pipeline: normalize, length by square root, divide per component.
// Depends on ssp_pkg, ssp_delay, ssp_isqrt, ssp_div.
module ssp_unit (
   input  logic              clock,
   input  logic              reset,
   input  ssp_pkg::vec_type  vec_i,
   output ssp_pkg::unit_type unit_o,
   output logic              near_o
);

   localparam int OW  = ssp_pkg::OFF_W;
   localparam int NW  = ssp_pkg::NORM_W;
   localparam int SW  = 2 * ssp_pkg::NORM_W;
   localparam int LW  = ssp_pkg::ISQ_UNIT_IW / 2;
   localparam int QW  = ssp_pkg::DIV_U_QW;
   localparam int PW  = 6;
   localparam int NM_DLY   = 2 + LW;
   localparam int FLAG_DLY = ssp_pkg::LAT_UNIT - 4;

   logic [2:0][OW-1:0] mag1_ff, mag2_ff, mag3_ff;
   logic [2:0]         neg1_ff, neg2_ff, neg3_ff;
   logic [OW-1:0]      or2_ff;
   logic               near2_ff, near3_ff, near_in;
   logic [PW-1:0]      pos3_ff, pos_in;
   logic [2:0][NW-1:0] nm4_ff, nm_in, nm_d;
   logic [2:0][SW-1:0] sq5_ff;
   logic [ssp_pkg::ISQ_UNIT_IW-1:0] sum6_ff;
   logic [LW-1:0]      len;
   logic [2:0][QW-1:0] quo;
   logic [3:0]         flag_d;
   ssp_pkg::unit_type  unit_ff, unit_in;
   logic               near_ff;
   logic [6:0]         sqsum;

   // magnitude and sign
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         mag1_ff[i] <= vec_i[i][OW-1] ? (~vec_i[i] + OW'(1)) : vec_i[i];
         neg1_ff[i] <= vec_i[i][OW-1];
      end
   end

   // near-zero test: any magnitude above six already fails it
   always_comb begin
      sqsum   = 7'(mag1_ff[0][2:0]) * 7'(mag1_ff[0][2:0])
              + 7'(mag1_ff[1][2:0]) * 7'(mag1_ff[1][2:0])
              + 7'(mag1_ff[2][2:0]) * 7'(mag1_ff[2][2:0]);
      near_in = (sqsum <= ssp_pkg::NEAR_ZERO_SQ);
      for (int i = 0; i < 3; i++) begin
         if (mag1_ff[i][OW-1:3] != '0 || mag1_ff[i][2:0] > ssp_pkg::NEAR_ZERO_MAG)
            near_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      or2_ff   <= mag1_ff[0] | mag1_ff[1] | mag1_ff[2];
      near2_ff <= near_in;
      mag2_ff  <= mag1_ff;
      neg2_ff  <= neg1_ff;
   end

   // leading one of the largest magnitude
   always_comb begin
      pos_in = '0;
      for (int i = 0; i < OW; i++) begin
         if (or2_ff[i]) pos_in = PW'(i);
      end
   end

   always_ff @(posedge clock) begin
      pos3_ff  <= pos_in;
      mag3_ff  <= mag2_ff;
      neg3_ff  <= neg2_ff;
      near3_ff <= near2_ff;
   end

   // scale so the largest magnitude sits in [2^29, 2^30)
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (pos3_ff > PW'(NW - 1))
            nm_in[i] = NW'(mag3_ff[i] >> (pos3_ff - PW'(NW - 1)));
         else
            nm_in[i] = NW'(mag3_ff[i] << (PW'(NW - 1) - pos3_ff));
      end
   end

   always_ff @(posedge clock) begin
      nm4_ff <= nm_in;
      for (int i = 0; i < 3; i++) sq5_ff[i] <= SW'(nm4_ff[i]) * SW'(nm4_ff[i]);
      sum6_ff <= ssp_pkg::ISQ_UNIT_IW'(sq5_ff[0]) + ssp_pkg::ISQ_UNIT_IW'(sq5_ff[1])
               + ssp_pkg::ISQ_UNIT_IW'(sq5_ff[2]);
   end

   ssp_isqrt #(.IW(ssp_pkg::ISQ_UNIT_IW)) u_len (
      .clock  (clock),
      .x_i    (sum6_ff),
      .root_o (len)
   );

   ssp_delay #(.W(3 * NW), .N(NM_DLY)) u_nm_dly (
      .clock (clock),
      .reset (reset),
      .d_i   (nm4_ff),
      .q_o   (nm_d)
   );

   // component / length in Q2.30
   for (genvar i = 0; i < 3; i++) begin : g_div
      ssp_div #(.DW(LW), .QW(QW)) u_div (
         .clock (clock),
         .hi_i  (LW'(nm_d[i][NW-1:1])),
         .lo_i  ({nm_d[i][0], (QW - 1)'(0)}),
         .den_i (len),
         .quo_o (quo[i])
      );
   end

   ssp_delay #(.W(4), .N(FLAG_DLY)) u_flag_dly (
      .clock (clock),
      .reset (reset),
      .d_i   ({neg3_ff, near3_ff}),
      .q_o   (flag_d)
   );

   // restore signs
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         unit_in[i] = flag_d[i+1] ? (~{1'b0, quo[i]} + ssp_pkg::UNIT_W'(1)) : {1'b0, quo[i]};
      end
   end

   always_ff @(posedge clock) begin
      unit_ff <= unit_in;
      near_ff <= flag_d[0];
   end

   assign unit_o = unit_ff;
   assign near_o = near_ff;

endmodule

[hdl/ssp_atten.sv]
// Distance and smoothstep attenuation pipeline.
// Depends on ssp_pkg, ssp_delay, ssp_isqrt, ssp_div.
module ssp_atten (
   input  logic                       clock,
   input  logic                       reset,
   input  ssp_pkg::vec_type           off_i,
   input  logic [ssp_pkg::CFG_W-1:0]  min_i,
   input  logic [ssp_pkg::CFG_W-1:0]  max_i,
   output logic [ssp_pkg::ATT_W-1:0]  att_o
);

   localparam int OW = ssp_pkg::OFF_W;
   localparam int HW = ssp_pkg::ISQ_DIST_IW / 2;
   localparam int IW = ssp_pkg::ISQ_DIST_IW;
   localparam int CW = ssp_pkg::CFG_W;
   localparam int TW = ssp_pkg::DIV_T_QW;
   localparam int BIG_DLY  = HW + 2;
   localparam int FLAG_DLY = TW + 2;

   logic [2:0][OW-1:0] mag1_ff;
   logic [2:0][HW-1:0] h2_ff;
   logic               big2_ff, big_d;
   logic [2:0][IW-1:0] sq3_ff;
   logic [IW-1:0]      sum4_ff;
   logic [HW-1:0]      root;
   logic [OW-1:0]      dist5_ff;
   logic [CW-1:0]      mn, mxd, diff6_ff, den6_ff;
   logic               le6_ff, ge6_ff;
   logic [1:0]         flag_d;
   logic [TW-1:0]      t, t7_ff;
   logic [2*TW-1:0]    tt7_ff;
   logic [2*TW+17:0]   prod8_ff;
   logic [ssp_pkg::ATT_W-1:0] att9_ff;
   logic               big_in;

   assign big_in = |(mag1_ff[0][OW-1:OW-2] | mag1_ff[1][OW-1:OW-2] | mag1_ff[2][OW-1:OW-2]);

   // magnitudes, halved when any reaches 2^31, then squares and sum
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         mag1_ff[i] <= off_i[i][OW-1] ? (~off_i[i] + OW'(1)) : off_i[i];
         h2_ff[i]   <= big_in ? mag1_ff[i][OW-1:1] : mag1_ff[i][HW-1:0];
         sq3_ff[i]  <= IW'(h2_ff[i]) * IW'(h2_ff[i]);
      end
      big2_ff <= big_in;
      sum4_ff <= sq3_ff[0] + sq3_ff[1] + sq3_ff[2];
   end

   ssp_isqrt #(.IW(IW)) u_root (
      .clock  (clock),
      .x_i    (sum4_ff),
      .root_o (root)
   );

   ssp_delay #(.W(1), .N(BIG_DLY)) u_big_dly (
      .clock (clock),
      .reset (reset),
      .d_i   (big2_ff),
      .q_o   (big_d)
   );

   // effective limits from the registers
   assign mn  = (min_i < ssp_pkg::MIN_FLOOR) ? ssp_pkg::MIN_FLOOR : min_i;
   assign mxd = (max_i < mn) ? mn : max_i;

   always_ff @(posedge clock) begin
      dist5_ff <= big_d ? {root, 1'b0} : {1'b0, root};
      le6_ff   <= (dist5_ff <= {1'b0, mn});
      ge6_ff   <= (dist5_ff >= {1'b0, mxd});
      diff6_ff <= CW'(dist5_ff - {1'b0, mn});
      den6_ff  <= mxd - mn;
   end

   ssp_div #(.DW(CW), .QW(TW)) u_t (
      .clock (clock),
      .hi_i  (diff6_ff),
      .lo_i  ('0),
      .den_i (den6_ff),
      .quo_o (t)
   );

   ssp_delay #(.W(2), .N(FLAG_DLY)) u_flag_dly (
      .clock (clock),
      .reset (reset),
      .d_i   ({le6_ff, ge6_ff}),
      .q_o   (flag_d)
   );

   // smoothstep: t*t*(3 - 2t)
   always_ff @(posedge clock) begin
      t7_ff    <= t;
      tt7_ff   <= (2 * TW)'(t) * (2 * TW)'(t);
      prod8_ff <= (2 * TW + 18)'(tt7_ff) * (2 * TW + 18)'(18'd196608 - {1'b0, t7_ff, 1'b0});
      if (flag_d[1])
         att9_ff <= ssp_pkg::ATT_ONE;
      else if (flag_d[0])
         att9_ff <= '0;
      else
         att9_ff <= ssp_pkg::ATT_ONE - prod8_ff[2*TW+16:2*TW];
   end

   assign att_o = att9_ff;

endmodule

[tb/spatializer_checker.sv]
// Checker for the stereo audio spatializer: watches input beats, config writes
// and result strobes, predicts each result in fixed point and compares it.
// Depends on ssp_pkg.
`timescale 1ns / 100ps

module spatializer_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  ssp_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  ssp_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [ssp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ssp_pkg::CFG_W-1:0]     csr_wdata,
   output int                            fail_count,
   output int                            pending_count
);
   import ssp_pkg::*;

   logic [31:0] min_dist_reg;
   logic [31:0] max_dist_reg;
   rsp_type     expected_q[$];

   // bitwise floor square root
   function automatic logic [63:0] floor_root(input logic [63:0] x);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] magnitude(input logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   function automatic bit is_tiny(input logic signed [63:0] v[3]);
      logic [63:0] acc;
      logic [63:0] a;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
         a = magnitude(v[i]);
         if (a >= 65536) return 0;
         acc += a * a;
      end
      return acc <= 42;
   endfunction

   // Q2.30 unit vector after power-of-two normalization
   function automatic void to_unit(input logic signed [63:0] v[3],
                                   output logic signed [63:0] u[3]);
      logic [63:0] m[3];
      logic [63:0] peak;
      logic [63:0] acc;
      logic [63:0] len;
      logic [63:0] q;
      peak = 0;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = magnitude(v[i]);
         if (m[i] > peak) peak = m[i];
      end
      while (peak >= (64'd1 << 30)) begin
         peak = peak >> 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      end
      while (peak < (64'd1 << 29)) begin
         peak = peak << 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      end
      for (int i = 0; i < 3; i++) acc += m[i] * m[i];
      len = floor_root(acc);
      for (int i = 0; i < 3; i++) begin
         q = (m[i] << 30) / len;
         u[i] = v[i] < 0 ? -$signed(q) : $signed(q);
      end
   endfunction

   function automatic rsp_type spatialize(input req_type s);
      rsp_type r;
      logic signed [63:0] off[3];
      logic signed [63:0] ear[3];
      logic signed [63:0] ud[3];
      logic signed [63:0] ur[3];
      logic signed [63:0] dot;
      logic signed [63:0] pan_v;
      logic [63:0] mg[3];
      logic [63:0] peak;
      logic [63:0] acc;
      logic [63:0] dist_v;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] att;
      logic [63:0] t;
      logic [63:0] g;
      logic [63:0] vol;
      logic [63:0] rounded;
      r = '0;
      if (!s.enabled) return r;
      off[0] = 64'(s.source_x) - 64'(s.listener_x);
      off[1] = 64'(s.source_y) - 64'(s.listener_y);
      off[2] = 64'(s.source_z) - 64'(s.listener_z);
      ear[0] = 64'(s.ear_axis_x);
      ear[1] = 64'(s.ear_axis_y);
      ear[2] = 64'(s.ear_axis_z);
      peak = 0;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
         mg[i] = magnitude(off[i]);
         if (mg[i] > peak) peak = mg[i];
      end
      if (peak < (64'd1 << 31)) begin
         for (int i = 0; i < 3; i++) acc += mg[i] * mg[i];
         dist_v = floor_root(acc);
      end else begin
         for (int i = 0; i < 3; i++) acc += (mg[i] >> 1) * (mg[i] >> 1);
         dist_v = floor_root(acc) << 1;
      end
      // distance falloff
      lo = min_dist_reg < 66 ? 64'd66 : 64'(min_dist_reg);
      hi = max_dist_reg < lo ? lo : 64'(max_dist_reg);
      if (dist_v <= lo) att = 65536;
      else if (dist_v >= hi) att = 0;
      else begin
         t = ((dist_v - lo) << 16) / (hi - lo);
         att = 65536 - ((t * t * (196608 - 2 * t)) >> 32);
      end
      // pan from unit direction and ear axis
      if (is_tiny(ear)) begin
         ur[0] = 64'sd1 << 30;
         ur[1] = 0;
         ur[2] = 0;
      end else to_unit(ear, ur);
      pan_v = 0;
      if (!is_tiny(off)) begin
         to_unit(off, ud);
         dot = 0;
         for (int i = 0; i < 3; i++) dot += ud[i] * ur[i];
         rounded = dot + (64'd1 << 62) + (64'd1 << 44);
         pan_v = $signed(rounded >> 45) - (64'sd1 << 17);
         if (pan_v > 32767) pan_v = 32767;
         if (pan_v < -32768) pan_v = -32768;
      end
      vol = s.volume < 0 ? 64'd0 : 64'(s.volume);
      g = (vol * att) >> 16;
      r.gain = g[14:0];
      r.left_gain = 15'((g * floor_root(64'(32768 - pan_v) << 16)) >> 16);
      r.right_gain = 15'((g * floor_root(64'(32768 + pan_v) << 16)) >> 16);
      r.attenuation = att[16:0];
      r.pan = pan_v[15:0];
      r.audible = g != 0;
      return r;
   endfunction

   assign pending_count = expected_q.size();

   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         min_dist_reg <= MIN_DIST_RESET;
         max_dist_reg <= MAX_DIST_RESET;
         fail_count <= 0;
         expected_q.delete();
      end else begin
         if (start && !busy) expected_q.push_back(spatialize(req_data));
         if (csr_we) begin
            if (csr_index == CSR_MIN_DISTANCE) min_dist_reg <= csr_wdata;
            else if (csr_index == CSR_MAX_DISTANCE) max_dist_reg <= csr_wdata;
         end
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               $error("result beat with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_q.pop_front();
               if (rsp_data !== exp_r) begin
                  fail_count <= fail_count + 1;
                  if (rsp_data.gain !== exp_r.gain)
                     $error("gain exp %0d got %0d", exp_r.gain, rsp_data.gain);
                  if (rsp_data.left_gain !== exp_r.left_gain)
                     $error("left_gain exp %0d got %0d", exp_r.left_gain,
                            rsp_data.left_gain);
                  if (rsp_data.right_gain !== exp_r.right_gain)
                     $error("right_gain exp %0d got %0d", exp_r.right_gain,
                            rsp_data.right_gain);
                  if (rsp_data.attenuation !== exp_r.attenuation)
                     $error("attenuation exp %0d got %0d", exp_r.attenuation,
                            rsp_data.attenuation);
                  if (rsp_data.pan !== exp_r.pan)
                     $error("pan exp %0d got %0d", exp_r.pan, rsp_data.pan);
                  if (rsp_data.audible !== exp_r.audible)
                     $error("audible exp %0d got %0d", exp_r.audible,
                            rsp_data.audible);
               end
            end
         end
      end
   end

endmodule

[tb/tb.sv]
// Top of the spatializer testbench: clock, reset, config phases and source
// stimulus; checking is done by spatializer_checker. Depends on ssp_pkg and stereo_audio_spatializer_top.
`timescale 1ns / 100ps

module tb;
   import ssp_pkg::*;

   localparam int DRAIN_CYCLES = 200;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_data;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;
   int                   fail_count;
   int                   pending_count;

   stereo_audio_spatializer_top uut (.*);

   spatializer_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [31:0] rand_coord(input int mode);
      case (mode)
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
         2: return 32'($signed($urandom_range(0, 16)) - 8);
         default: return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
      endcase
   endfunction

   function automatic req_type random_source();
      req_type s;
      int m;
      int near_mode;
      s.enabled = $urandom_range(0, 9) != 0;
      s.volume = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 8192));
      m = $urandom_range(0, 3);
      near_mode = $urandom_range(0, 7) == 0 ? 2 : m;
      s.listener_x = rand_coord(m);
      s.listener_y = rand_coord(m);
      s.listener_z = rand_coord(m);
      s.source_x = s.listener_x + rand_coord(near_mode);
      s.source_y = s.listener_y + rand_coord(near_mode);
      s.source_z = s.listener_z + rand_coord(near_mode);
      if (m == 0) begin
         s.source_x = $urandom;
         s.source_y = $urandom;
         s.source_z = $urandom;
      end
      s.ear_axis_x = rand_coord($urandom_range(0, 3));
      s.ear_axis_y = rand_coord($urandom_range(0, 3));
      s.ear_axis_z = rand_coord($urandom_range(0, 3));
      return s;
   endfunction

   task automatic send_source(input req_type s, input int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= s;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic req_type directed_source(input int k);
      req_type s;
      s = '0;
      s.enabled = 1'b1;
      s.volume = 16'sd4096;
      s.ear_axis_x = 32'sd65536;
      case (k)
         0: s.enabled = 1'b0;
         1: s.source_x = 32'sd131072;                         // right
         2: s.source_x = -32'sd131072;                        // left
         3: s.source_y = 32'sd131072;                         // center
         4: s.source_z = 32'sd3;                              // tiny offset
         5: begin s.ear_axis_x = 32'sd2; s.source_x = -32'sd655360; end
         6: begin s.source_x = 32'h7FFFFFFF; s.listener_x = 32'h80000000; end
         7: begin
            s.source_x = 32'h80000000; s.source_y = 32'h7FFFFFFF;
            s.listener_x = 32'h7FFFFFFF; s.listener_y = 32'h80000000;
            s.source_z = 32'h7FFFFFFF; s.listener_z = 32'h80000000;
            s.ear_axis_x = 32'h80000000; s.ear_axis_y = 32'h7FFFFFFF;
            s.ear_axis_z = 32'hFFFFFFFF;
         end
         8: begin s.volume = 16'sh7FFF; s.source_x = 32'sd65536; end
         9: begin s.volume = 16'sh8000; s.source_x = 32'sd65536; end
         10: s.source_x = 32'sd6553600;                        // at maximum
         11: s.source_y = 32'sd3276800;
         12: begin s.volume = 16'sh7FFF; s.ear_axis_x = 32'sd0; s.source_x = 32'sd1000; end
         13: begin s.volume = 16'sd1; s.source_z = 32'sd200000; end
         default: begin
            s.ear_axis_x = 32'h7FFFFFFF; s.ear_axis_y = 32'h7FFFFFFF;
            s.source_x = 32'sd100000; s.source_y = 32'sd100000;
         end
      endcase
      return s;
   endfunction

   initial begin
      int idle_pct;
      logic [31:0] lo_val;
      logic [31:0] hi_val;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_MIN_DISTANCE;
      csr_wdata = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);

      // directed sources at reset settings
      for (int k = 0; k < 15; k++) send_source(directed_source(k), 0);
      drain();
      // equal min and max, then extremes of both registers
      write_reg(CSR_MIN_DISTANCE, 32'd131072);
      write_reg(CSR_MAX_DISTANCE, 32'd131072);
      send_source(directed_source(1), 0);
      send_source(directed_source(3), 0);
      drain();
      write_reg(CSR_MIN_DISTANCE, 32'd0);
      write_reg(CSR_MAX_DISTANCE, 32'hFFFFFFFF);
      for (int k = 1; k < 8; k++) send_source(directed_source(k), 0);
      drain();

      // random phases with changing distances and idle rates
      for (int p = 0; p < 9; p++) begin
         case (p % 3)
            0: idle_pct = 0;
            1: idle_pct = 81;
            default: idle_pct = 23;
         endcase
         case (p)
            0: begin lo_val = 32'd65536; hi_val = 32'd6553600; end
            1: begin lo_val = 32'hFFFFFFFF; hi_val = 32'd0; end
            2: begin lo_val = 32'd0; hi_val = 32'd0; end
            default: begin
               lo_val = $urandom_range(0, 20 << 16);
               hi_val = $urandom_range(0, 300 << 16);
            end
         endcase
         write_reg(CSR_MIN_DISTANCE, lo_val);
         write_reg(CSR_MAX_DISTANCE, hi_val);
         for (int n = 0; n < 150; n++) send_source(random_source(), idle_pct);
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

[filelist.f]
+incdir+hdl
hdl/ssp_pkg.sv
hdl/ssp_delay.sv
hdl/ssp_isqrt.sv
hdl/ssp_div.sv
hdl/ssp_unit.sv
hdl/ssp_atten.sv
hdl/stereo_audio_spatializer_top.sv
tb/spatializer_checker.sv
tb/tb.sv
